@@ rtl/core/pts_pkg.sv @@
package pts_pkg;

    localparam int POS_W      = 16;
    localparam int GAIN_W     = 9;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 5;

    typedef logic [1:0] t_law;

    localparam t_law LAW_TABLE = 2'd0;
    localparam t_law LAW_SWAP  = 2'd1;
    localparam t_law LAW_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CURVE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LAW    = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UNITY  = 9'd256;
    localparam logic [GAIN_W-1:0] STEP_TOP    = 9'd255;
    localparam logic [GAIN_W-1:0] STEP_SIZE   = 9'd25;
    localparam logic [7:0]        STEP_CENTER = 8'd10;
    // farthest step that still stays at or above zero
    localparam logic [7:0]        STEP_MAX    = 8'd10;

    typedef struct packed {
        t_law law;
        logic empty;
    } t_cfg;

endpackage

@@ rtl/core/pts_pan_if.sv @@
interface pts_pan_if;
    logic                        valid;
    logic                        ready;
    logic [pts_pkg::POS_W-1:0]   pan_position;

    modport source (output valid, output pan_position, input ready);
    modport sink   (input valid, input pan_position, output ready);
endinterface

@@ rtl/core/pts_gain_if.sv @@
interface pts_gain_if;
    logic                        valid;
    logic                        ready;
    logic [pts_pkg::GAIN_W-1:0]  gain_left;
    logic [pts_pkg::GAIN_W-1:0]  gain_right;
    logic                        gain_clipped;

    modport source (output valid, output gain_left, output gain_right,
                    output gain_clipped, input ready);
    modport sink   (input valid, input gain_left, input gain_right,
                    input gain_clipped, output ready);
endinterface

@@ rtl/core/pan_table_stereo_balance.sv @@
// Stereo balance from a pan position: each pan_position item (index in the
// high byte, fraction in the low byte) gives one item of left/right gains in
// 1/256 units, 256 being unity. Table laws interpolate a loaded curve of up to
// CURVE_ENTRIES bytes at the position and at its mirror, doubled; the step
// law gives 255 minus 25 per step from index 10 and flags saturation at zero.
// The path is two registers deep (input register, result register): an item
// is captured in the input register, and its gains are offered on the output
// from the result register; one item is taken every cycle while the output
// side keeps up. Write configuration only while no items are in flight.
module pan_table_stereo_balance #(
    parameter int CURVE_ENTRIES = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pts_pan_if.sink                         i_pan,
    pts_gain_if.source                      o_gain
);

    localparam int LAST_W = $clog2(CURVE_ENTRIES);

    logic [7:0]                 curve [CURVE_ENTRIES];
    logic [LAST_W-1:0]          last;
    pts_pkg::t_cfg              cfg;

    logic                       r_in_valid;
    logic [pts_pkg::POS_W-1:0]  r_pos;
    logic                       r_out_valid;
    logic [pts_pkg::GAIN_W-1:0] r_left;
    logic [pts_pkg::GAIN_W-1:0] r_right;
    logic                       r_clipped;

    logic [pts_pkg::GAIN_W-1:0] n_left;
    logic [pts_pkg::GAIN_W-1:0] n_right;
    logic                       n_clipped;

    logic                       out_adv;
    logic                       in_adv;

    pts_cfg_regs #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_curve    (curve),
        .o_last     (last),
        .o_cfg      (cfg)
    );

    pts_gain_core #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_core (
        .i_pos      (r_pos),
        .i_curve    (curve),
        .i_last     (last),
        .i_cfg      (cfg),
        .o_left     (n_left),
        .o_right    (n_right),
        .o_clipped  (n_clipped)
    );

    assign out_adv     = !r_out_valid || o_gain.ready;
    assign in_adv      = !r_in_valid || out_adv;
    assign i_pan.ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_pan.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_pan.valid) begin
            r_pos <= i_pan.pan_position;
        end
        if (out_adv && r_in_valid) begin
            r_left    <= n_left;
            r_right   <= n_right;
            r_clipped <= n_clipped;
        end
    end

    assign o_gain.valid        = r_out_valid;
    assign o_gain.gain_left    = r_left;
    assign o_gain.gain_right   = r_right;
    assign o_gain.gain_clipped = r_clipped;

endmodule

@@ rtl/core/pts_cfg_regs.sv @@
module pts_cfg_regs #(
    parameter int CURVE_ENTRIES = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [7:0]                        o_curve [CURVE_ENTRIES],
    output logic [$clog2(CURVE_ENTRIES)-1:0]  o_last,
    output pts_pkg::t_cfg                     o_cfg
);

    localparam int LAST_W = $clog2(CURVE_ENTRIES);

    logic [7:0]                   r_curve [CURVE_ENTRIES];
    logic [LAST_W-1:0]            r_last;
    logic                         r_empty;
    pts_pkg::t_law                r_law;
    logic [pts_pkg::LEN_W-1:0]    len_sat;

    genvar e;
    generate
        for (e = 0; e < CURVE_ENTRIES; e++) begin : g_entry
            localparam int WORD = e / 8;
            localparam int BYTE = e % 8;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_curve[e] <= 8'd0;
                end else if (i_cfg_we &&
                             i_cfg_idx == pts_pkg::REG_CURVE_LOW +
                                          pts_pkg::CFG_IDX_W'(WORD)) begin
                    r_curve[e] <= i_cfg_data[BYTE*8 +: 8];
                end
            end
            assign o_curve[e] = r_curve[e];
        end
    endgenerate

    assign len_sat = (i_cfg_data[pts_pkg::LEN_W-1:0] > pts_pkg::LEN_W'(CURVE_ENTRIES))
                   ? pts_pkg::LEN_W'(CURVE_ENTRIES)
                   : i_cfg_data[pts_pkg::LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_empty <= 1'b1;
            r_law   <= pts_pkg::LAW_TABLE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pts_pkg::REG_CURVE_LEN) begin
                r_empty <= (len_sat == '0);
                r_last  <= LAST_W'(len_sat - pts_pkg::LEN_W'(1));
            end
            if (i_cfg_idx == pts_pkg::REG_PAN_LAW) begin
                r_law <= i_cfg_data[1:0];
            end
        end
    end

    assign o_last      = r_last;
    assign o_cfg.law   = r_law;
    assign o_cfg.empty = r_empty;

endmodule

@@ rtl/core/pts_curve_read.sv @@
module pts_curve_read #(
    parameter int CURVE_ENTRIES = 24
) (
    input  logic [pts_pkg::POS_W-1:0]         i_pos,
    input  logic [7:0]                        i_curve [CURVE_ENTRIES],
    input  logic [$clog2(CURVE_ENTRIES)-1:0]  i_last,
    output logic [pts_pkg::GAIN_W-1:0]        o_gain
);

    localparam int LAST_W = $clog2(CURVE_ENTRIES);

    logic [7:0]        idx_raw;
    logic              over;
    logic [LAST_W-1:0] idx;
    logic [LAST_W-1:0] idx_nxt;
    logic [7:0]        frac;
    logic [7:0]        v;
    logic [7:0]        n;
    logic [7:0]        delta;
    logic [15:0]       prod;
    logic [7:0]        res;

    assign idx_raw = i_pos[15:8];
    assign over    = idx_raw > 8'(i_last);
    assign idx     = over ? i_last : LAST_W'(idx_raw);
    assign frac    = over ? 8'd0 : i_pos[7:0];
    assign idx_nxt = (idx < i_last) ? LAST_W'(idx + LAST_W'(1)) : idx;
    assign v       = i_curve[idx];
    assign n       = i_curve[idx_nxt];
    assign delta   = n - v;
    assign prod    = 16'(delta) * 16'(frac);
    assign res     = v + prod[15:8];
    assign o_gain  = {res, 1'b0};

endmodule

@@ rtl/core/pts_gain_core.sv @@
module pts_gain_core #(
    parameter int CURVE_ENTRIES = 24
) (
    input  logic [pts_pkg::POS_W-1:0]         i_pos,
    input  logic [7:0]                        i_curve [CURVE_ENTRIES],
    input  logic [$clog2(CURVE_ENTRIES)-1:0]  i_last,
    input  pts_pkg::t_cfg                     i_cfg,
    output logic [pts_pkg::GAIN_W-1:0]        o_left,
    output logic [pts_pkg::GAIN_W-1:0]        o_right,
    output logic                              o_clipped
);

    logic [7:0]                 idx;
    logic [15:0]                last_pos;
    logic [15:0]                pos_c;
    logic [15:0]                mirror;
    logic [pts_pkg::GAIN_W-1:0] tab_a;
    logic [pts_pkg::GAIN_W-1:0] tab_b;
    logic [7:0]                 step_dist;
    logic [pts_pkg::GAIN_W-1:0] step_drop;

    assign idx      = i_pos[15:8];
    assign last_pos = {8'(i_last), 8'h00};
    assign pos_c    = (idx > 8'(i_last)) ? last_pos : i_pos;
    assign mirror   = last_pos - pos_c;

    pts_curve_read #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_read_a (
        .i_pos   (pos_c),
        .i_curve (i_curve),
        .i_last  (i_last),
        .o_gain  (tab_a)
    );

    pts_curve_read #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_read_b (
        .i_pos   (mirror),
        .i_curve (i_curve),
        .i_last  (i_last),
        .o_gain  (tab_b)
    );

    // distance from the center step, either side
    assign step_dist = (idx <= pts_pkg::STEP_CENTER) ? pts_pkg::STEP_CENTER - idx
                                                     : idx - pts_pkg::STEP_CENTER;
    assign step_drop = pts_pkg::GAIN_W'(step_dist[3:0]) * pts_pkg::STEP_SIZE;

    always_comb begin
        o_left    = pts_pkg::GAIN_UNITY;
        o_right   = pts_pkg::GAIN_UNITY;
        o_clipped = 1'b0;
        case (i_cfg.law)
            pts_pkg::LAW_STEP: begin
                if (idx <= pts_pkg::STEP_CENTER) begin
                    o_left = pts_pkg::STEP_TOP - step_drop;
                end else if (step_dist > pts_pkg::STEP_MAX) begin
                    o_right   = '0;
                    o_clipped = 1'b1;
                end else begin
                    o_right = pts_pkg::STEP_TOP - step_drop;
                end
            end
            pts_pkg::LAW_SWAP: begin
                if (!i_cfg.empty) begin
                    o_left  = tab_b;
                    o_right = tab_a;
                end
            end
            default: begin
                if (!i_cfg.empty) begin
                    o_left  = tab_a;
                    o_right = tab_b;
                end
            end
        endcase
    end

endmodule
